[design/scw_pkg.sv]
// Shared types and constants for the scan point window clustering block.
// No dependencies.
`default_nettype none
package scw_pkg;
   localparam int COORD_W = 16;
   localparam int GROUP_W = 8;
   localparam int SIZE_W  = 12;
   localparam int BACK_W  = 4;
   localparam int DIST_W  = 33;
   localparam int MAG_W   = 16;
   localparam int GROUP_IDS = 256;
   localparam logic [SIZE_W-1:0] SIZE_MAX = 12'd4095;
   // a freshly opened group holds the neighbor and the new point
   localparam logic [SIZE_W-1:0] SIZE_OPEN = 12'd2;
   localparam logic [DIST_W-1:0] LINK_RESET = 33'd40000;

   // One window entry: a point and its group id.
   typedef struct packed {
      logic signed [COORD_W-1:0] x;
      logic signed [COORD_W-1:0] y;
      logic [GROUP_W-1:0]        grp;
   } entry_type;

   // Control shared by every cell of the window chain.
   typedef struct packed {
      logic               advance;
      logic               clear;
      logic [GROUP_W-1:0] label_grp;
   } cell_ctrl_type;
endpackage
`default_nettype wire

[design/scw_cell.sv]
// One window cell: holds a point and its group, loads from its neighbor.
// Depends on scw_pkg.
`default_nettype none
module scw_cell (
   input  wire                   clock,
   input  scw_pkg::cell_ctrl_type ctrl,
   input  wire                   label_hit,
   input  scw_pkg::entry_type    prev_in,
   output scw_pkg::entry_type    entry_out
);
   import scw_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.advance) begin
         entry_in = prev_in;
         // label the neighbor that opened a group as it moves past
         if (label_hit) begin
            entry_in.grp = ctrl.label_grp;
         end
      end else if (ctrl.clear) begin
         entry_in.grp = '0;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

   assign entry_out = entry_ff;
endmodule
`default_nettype wire

[design/scw_dist.sv]
// Squared distance pipeline with nearest-entry tracking.
// Depends on scw_pkg.
`default_nettype none
module scw_dist #(
   parameter int IDX_W = 4
) (
   input  wire                         clock,
   input  wire                         reset,
   input  wire                         start,
   input  wire                         issue,
   input  wire [IDX_W-1:0]             issue_idx,
   input  wire signed [scw_pkg::COORD_W-1:0] point_x,
   input  wire signed [scw_pkg::COORD_W-1:0] point_y,
   input  scw_pkg::entry_type          tail,
   output logic [IDX_W-1:0]            best_idx,
   output logic [scw_pkg::DIST_W-1:0]  best_dist,
   output logic [scw_pkg::GROUP_W-1:0] best_grp
);
   import scw_pkg::*;

   logic signed [COORD_W:0] diff_x, diff_y;
   logic [COORD_W:0]        neg_x, neg_y;
   logic [MAG_W-1:0]        mag_x_in, mag_y_in;

   logic               s1_valid_ff, s2_valid_ff;
   logic [MAG_W-1:0]   s1_mag_x_ff, s1_mag_y_ff;
   logic [IDX_W-1:0]   s1_idx_ff, s2_idx_ff;
   logic [GROUP_W-1:0] s1_grp_ff, s2_grp_ff;
   logic [2*MAG_W-1:0] s2_sq_x_ff, s2_sq_y_ff;
   logic [DIST_W-1:0]  sum;
   logic               first_ff;
   logic [IDX_W-1:0]   best_idx_ff;
   logic [DIST_W-1:0]  best_dist_ff;
   logic [GROUP_W-1:0] best_grp_ff;

   always_comb begin
      diff_x = {point_x[COORD_W-1], point_x} - {tail.x[COORD_W-1], tail.x};
      diff_y = {point_y[COORD_W-1], point_y} - {tail.y[COORD_W-1], tail.y};
      neg_x  = -diff_x;
      neg_y  = -diff_y;
      mag_x_in = diff_x[COORD_W] ? neg_x[MAG_W-1:0] : diff_x[MAG_W-1:0];
      mag_y_in = diff_y[COORD_W] ? neg_y[MAG_W-1:0] : diff_y[MAG_W-1:0];
      sum = {1'b0, s2_sq_x_ff} + {1'b0, s2_sq_y_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         first_ff    <= 1'b1;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         if (start) begin
            first_ff <= 1'b1;
         end else if (s2_valid_ff) begin
            first_ff <= 1'b0;
         end
      end
      s1_mag_x_ff <= mag_x_in;
      s1_mag_y_ff <= mag_y_in;
      s1_idx_ff   <= issue_idx;
      s1_grp_ff   <= tail.grp;
      s2_sq_x_ff  <= s1_mag_x_ff * s1_mag_x_ff;
      s2_sq_y_ff  <= s1_mag_y_ff * s1_mag_y_ff;
      s2_idx_ff   <= s1_idx_ff;
      s2_grp_ff   <= s1_grp_ff;
      // entries arrive highest index first: ties go to the later, lower index
      if (s2_valid_ff && (first_ff || sum <= best_dist_ff)) begin
         best_idx_ff  <= s2_idx_ff;
         best_dist_ff <= sum;
         best_grp_ff  <= s2_grp_ff;
      end
   end

   assign best_idx  = best_idx_ff;
   assign best_dist = best_dist_ff;
   assign best_grp  = best_grp_ff;
endmodule
`default_nettype wire

[design/scan_point_window_clustering.sv]
// Scan point window clustering: links each point to its nearest recent neighbor.
// With a full window each point rotates the window through the distance pipeline, is decided,
// may have its group's count looked up, and is inserted; otherwise it is inserted directly.
// A new point is accepted only in idle, after the previous point has been inserted.
// Reset: synchronous, active high; clears control, fill and group counter, sets link limit.
// Group counts are kept in a 256-entry memory that is written when a group opens or grows.
`default_nettype none
module scan_point_window_clustering #(
   parameter int WINDOW     = 15,
   parameter int MAX_GROUPS = 255
) (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_valid,
   output logic                              req_ready,
   input  wire signed [scw_pkg::COORD_W-1:0] req_point_x,
   input  wire signed [scw_pkg::COORD_W-1:0] req_point_y,
   input  wire                               req_scan_start,
   output logic                              rsp_valid,
   input  wire                               rsp_ready,
   output logic [scw_pkg::GROUP_W-1:0]       rsp_point_group,
   output logic [scw_pkg::BACK_W-1:0]        rsp_back_offset,
   output logic                              rsp_back_group_new,
   output logic [scw_pkg::SIZE_W-1:0]        rsp_group_size,
   output logic [scw_pkg::GROUP_W-1:0]       rsp_groups_total,
   output logic                              rsp_groups_overflow,
   input  wire                               csr_write,
   input  wire [scw_pkg::DIST_W-1:0]         csr_data
);
   import scw_pkg::*;

   localparam int IDX_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int FILL_W = $clog2(WINDOW + 1);
   localparam int CNT_W  = $clog2(WINDOW + 2);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_DECIDE, ST_LOOKUP, ST_INSERT
   } state_type;

   state_type          state_ff;
   logic [DIST_W-1:0]  link_ff;
   logic [FILL_W-1:0]  fill_ff;
   logic [GROUP_W-1:0] counter_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic signed [COORD_W-1:0] px_ff, py_ff;

   // pending result of the point in flight
   logic [GROUP_W-1:0] res_group_ff;
   logic [BACK_W-1:0]  res_back_ff;
   logic               res_new_ff;
   logic [SIZE_W-1:0]  res_size_ff;
   logic               res_ovf_ff;
   logic               label_en_ff;
   logic [IDX_W-1:0]   label_idx_ff;

   // output register
   logic               rsp_valid_ff;
   logic [GROUP_W-1:0] rsp_group_ff;
   logic [BACK_W-1:0]  rsp_back_ff;
   logic               rsp_new_ff;
   logic [SIZE_W-1:0]  rsp_size_ff;
   logic [GROUP_W-1:0] rsp_total_ff;
   logic               rsp_ovf_ff;

   // group count memory
   logic [SIZE_W-1:0]  count_mem [GROUP_IDS];
   logic [SIZE_W-1:0]  count_rd_ff;
   logic               count_we;
   logic [GROUP_W-1:0] count_wa;
   logic [SIZE_W-1:0]  count_wd;
   logic [SIZE_W-1:0]  size_next;

   logic               req_fire;
   logic               rotate;
   logic               insert_fire;
   logic               rsp_free;
   logic [IDX_W-1:0]   issue_idx;
   logic [IDX_W:0]     back_full;
   logic               hit;

   cell_ctrl_type      ctrl;
   entry_type          cell_q [WINDOW];
   entry_type          cell_d [WINDOW];
   logic               label_hit [WINDOW];
   entry_type          new_entry;

   logic [IDX_W-1:0]   best_idx;
   logic [DIST_W-1:0]  best_dist;
   logic [GROUP_W-1:0] best_grp;

   assign req_ready   = (state_ff == ST_IDLE);
   assign req_fire    = req_valid && req_ready;
   assign rsp_free    = !rsp_valid_ff || rsp_ready;
   assign rotate      = (state_ff == ST_SEARCH) && (cnt_ff < CNT_W'(WINDOW));
   assign insert_fire = (state_ff == ST_INSERT) && rsp_free;
   assign issue_idx   = IDX_W'(WINDOW - 1) - cnt_ff[IDX_W-1:0];
   assign back_full   = {1'b0, best_idx} + {{IDX_W{1'b0}}, 1'b1};
   assign hit         = best_dist < link_ff;
   assign size_next   = (count_rd_ff < SIZE_MAX) ? count_rd_ff + 1'b1 : count_rd_ff;

   // Cell chain: rotate during the search, shift the new point in at insert, clear groups at a scan start.
   always_comb begin
      ctrl.advance   = rotate || insert_fire;
      ctrl.clear     = req_fire && req_scan_start;
      ctrl.label_grp = res_group_ff;
      new_entry.x    = px_ff;
      new_entry.y    = py_ff;
      new_entry.grp  = res_group_ff;
   end

   generate
      for (genvar j = 0; j < WINDOW; j++) begin : g_cell
         if (j == 0) begin : g_head
            assign cell_d[j]    = rotate ? cell_q[WINDOW-1] : new_entry;
            assign label_hit[j] = 1'b0;
         end else begin : g_body
            assign cell_d[j]    = cell_q[j-1];
            // only the insert shift carries a retroactive label
            assign label_hit[j] = insert_fire && label_en_ff &&
                                  (label_idx_ff == IDX_W'(j - 1));
         end
         scw_cell u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .label_hit (label_hit[j]),
            .prev_in   (cell_d[j]),
            .entry_out (cell_q[j])
         );
      end
   endgenerate

   scw_dist #(.IDX_W(IDX_W)) u_dist (
      .clock     (clock),
      .reset     (reset),
      .start     (req_fire),
      .issue     (rotate),
      .issue_idx (issue_idx),
      .point_x   (px_ff),
      .point_y   (py_ff),
      .tail      (cell_q[WINDOW-1]),
      .best_idx  (best_idx),
      .best_dist (best_dist),
      .best_grp  (best_grp)
   );

   // Count memory: write on group open or count update, read the neighbor's count.
   always_comb begin
      count_we = 1'b0;
      count_wa = best_grp;
      count_wd = size_next;
      if (state_ff == ST_DECIDE && hit && best_grp == '0 &&
          counter_ff < GROUP_W'(MAX_GROUPS)) begin
         count_we = 1'b1;
         count_wa = counter_ff + 1'b1;
         count_wd = SIZE_OPEN;
      end else if (state_ff == ST_LOOKUP) begin
         count_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (count_we) begin
         count_mem[count_wa] <= count_wd;
      end
      count_rd_ff <= count_mem[best_grp];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         link_ff <= LINK_RESET;
      end else if (csr_write) begin
         link_ff <= csr_data;
      end
   end

   // Sequencer, window fill, group counter and the output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         fill_ff      <= '0;
         counter_ff   <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         label_en_ff  <= 1'b0;
      end else begin
         // drop valid once the transfer is taken, unless a new result loads now
         if (rsp_valid_ff && rsp_ready && !insert_fire) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_fire) begin
                  px_ff        <= req_point_x;
                  py_ff        <= req_point_y;
                  res_group_ff <= '0;
                  res_back_ff  <= '0;
                  res_new_ff   <= 1'b0;
                  res_size_ff  <= '0;
                  res_ovf_ff   <= 1'b0;
                  label_en_ff  <= 1'b0;
                  cnt_ff       <= '0;
                  if (req_scan_start) begin
                     fill_ff    <= '0;
                     counter_ff <= '0;
                     state_ff   <= ST_INSERT;
                  end else if (fill_ff == FILL_W'(WINDOW)) begin
                     state_ff <= ST_SEARCH;
                  end else begin
                     state_ff <= ST_INSERT;
                  end
               end
            end
            ST_SEARCH: begin
               // advance until the last distance has left the pipeline
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_W'(WINDOW + 1)) begin
                  state_ff <= ST_DECIDE;
               end
            end
            ST_DECIDE: begin
               if (!hit) begin
                  state_ff <= ST_INSERT;
               end else if (best_grp != '0) begin
                  res_group_ff <= best_grp;
                  state_ff     <= ST_LOOKUP;
               end else if (counter_ff < GROUP_W'(MAX_GROUPS)) begin
                  counter_ff   <= counter_ff + 1'b1;
                  res_group_ff <= counter_ff + 1'b1;
                  res_back_ff  <= BACK_W'(back_full);
                  res_new_ff   <= 1'b1;
                  res_size_ff  <= SIZE_OPEN;
                  label_en_ff  <= 1'b1;
                  label_idx_ff <= best_idx;
                  state_ff     <= ST_INSERT;
               end else begin
                  res_ovf_ff <= 1'b1;
                  state_ff   <= ST_INSERT;
               end
            end
            ST_LOOKUP: begin
               res_size_ff <= size_next;
               state_ff    <= ST_INSERT;
            end
            ST_INSERT: begin
               // hold until the output register can take the transfer
               if (rsp_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_group_ff <= res_group_ff;
                  rsp_back_ff  <= res_back_ff;
                  rsp_new_ff   <= res_new_ff;
                  rsp_size_ff  <= res_size_ff;
                  rsp_total_ff <= counter_ff;
                  rsp_ovf_ff   <= res_ovf_ff;
                  label_en_ff  <= 1'b0;
                  if (fill_ff != FILL_W'(WINDOW)) begin
                     fill_ff <= fill_ff + 1'b1;
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_point_group     = rsp_group_ff;
   assign rsp_back_offset     = rsp_back_ff;
   assign rsp_back_group_new  = rsp_new_ff;
   assign rsp_group_size      = rsp_size_ff;
   assign rsp_groups_total    = rsp_total_ff;
   assign rsp_groups_overflow = rsp_ovf_ff;
endmodule
`default_nettype wire

[test/scan_point_window_clustering_test.sv]
`timescale 1ns / 100ps
// Testbench for scan_point_window_clustering: a scoreboard class predicts each result.
// A plain task drives the point channel, an initial block the result channel. Depends on scw_pkg and the block.

class cluster_scoreboard #(int WINDOW_LEN = 15, int GROUP_LIMIT = 255);
   typedef struct packed {
      logic [scw_pkg::GROUP_W-1:0] grp;
      logic [scw_pkg::BACK_W-1:0]  back;
      logic                        back_new;
      logic [scw_pkg::SIZE_W-1:0]  size;
      logic [scw_pkg::GROUP_W-1:0] total;
      logic                        ovf;
   } cluster_result_t;

   logic [scw_pkg::DIST_W-1:0]         link_limit;
   logic signed [scw_pkg::COORD_W-1:0] win_x [WINDOW_LEN];
   logic signed [scw_pkg::COORD_W-1:0] win_y [WINDOW_LEN];
   logic [scw_pkg::GROUP_W-1:0]        win_grp [WINDOW_LEN];
   int unsigned                        fill;
   logic [scw_pkg::GROUP_W-1:0]        last_id;
   logic [scw_pkg::SIZE_W-1:0]         grp_size [scw_pkg::GROUP_IDS];
   cluster_result_t                    awaited_q [$];
   int unsigned                        mismatches;

   function void clear_state();
      link_limit = scw_pkg::LINK_RESET;
      foreach (win_x[k]) begin
         win_x[k] = '0;
         win_y[k] = '0;
         win_grp[k] = '0;
      end
      foreach (grp_size[g]) grp_size[g] = '0;
      fill = 0;
      last_id = '0;
      awaited_q.delete();
      mismatches = 0;
   endfunction

   function void set_link(logic [scw_pkg::DIST_W-1:0] value);
      link_limit = value;
   endfunction

   function int unsigned pending();
      return awaited_q.size();
   endfunction

   function logic [scw_pkg::DIST_W-1:0] sq_distance(
         logic signed [scw_pkg::COORD_W-1:0] ax, logic signed [scw_pkg::COORD_W-1:0] ay,
         logic signed [scw_pkg::COORD_W-1:0] bx, logic signed [scw_pkg::COORD_W-1:0] by);
      longint dx;
      longint dy;
      longint sum;
      logic [scw_pkg::DIST_W-1:0] d;
      dx = longint'(ax) - longint'(bx);
      dy = longint'(ay) - longint'(by);
      sum = dx * dx + dy * dy;
      d = sum[scw_pkg::DIST_W-1:0];
      return d;
   endfunction

   // Work out the result of one accepted point and update the window.
   function void note_point(logic signed [scw_pkg::COORD_W-1:0] px,
                            logic signed [scw_pkg::COORD_W-1:0] py, logic start);
      cluster_result_t res;
      int best;
      logic [scw_pkg::DIST_W-1:0] best_d;
      logic [scw_pkg::DIST_W-1:0] d;
      logic [scw_pkg::GROUP_W-1:0] g;
      res = '0;
      best = 0;
      best_d = '0;
      if (start) begin
         foreach (win_grp[k]) win_grp[k] = '0;
         fill = 0;
         last_id = '0;
      end
      if (fill >= WINDOW_LEN) begin
         for (int k = 0; k < WINDOW_LEN; k++) begin
            d = sq_distance(px, py, win_x[k], win_y[k]);
            if (k == 0 || d < best_d) begin
               best = k;
               best_d = d;
            end
         end
         if (best_d < link_limit) begin
            g = win_grp[best];
            if (g == 0) begin
               if (last_id < GROUP_LIMIT) begin
                  last_id = last_id + 1'b1;
                  g = last_id;
                  win_grp[best] = g;
                  grp_size[g] = 12'd1;
                  res.back = 4'(best + 1);
                  res.back_new = 1'b1;
               end else begin
                  res.ovf = 1'b1;
               end
            end
            if (g != 0) begin
               if (grp_size[g] < scw_pkg::SIZE_MAX) grp_size[g] = grp_size[g] + 1'b1;
               res.grp = g;
               res.size = grp_size[g];
            end
         end
      end
      for (int k = WINDOW_LEN - 1; k > 0; k--) begin
         win_x[k] = win_x[k-1];
         win_y[k] = win_y[k-1];
         win_grp[k] = win_grp[k-1];
      end
      win_x[0] = px;
      win_y[0] = py;
      win_grp[0] = res.grp;
      if (fill < WINDOW_LEN) fill++;
      res.total = last_id;
      awaited_q.push_back(res);
   endfunction

   function void compare_field(string name, longint unsigned exp_val,
                               longint unsigned act_val);
      if (exp_val != act_val) begin
         $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
         mismatches++;
      end
   endfunction

   function void check_result(cluster_result_t actual);
      cluster_result_t exp_res;
      if (awaited_q.size() == 0) begin
         $error("result transfer with no point awaiting it");
         mismatches++;
         return;
      end
      exp_res = awaited_q.pop_front();
      compare_field("point_group", exp_res.grp, actual.grp);
      compare_field("back_offset", exp_res.back, actual.back);
      compare_field("back_group_new", exp_res.back_new, actual.back_new);
      compare_field("group_size", exp_res.size, actual.size);
      compare_field("groups_total", exp_res.total, actual.total);
      compare_field("groups_overflow", exp_res.ovf, actual.ovf);
   endfunction
endclass

module scan_point_window_clustering_test;
   localparam int WINDOW_LEN   = 15;
   localparam int GROUP_LIMIT  = 255;
   // Settling time after draining, with a margin beyond what the block needs per point.
   localparam int DRAIN_CYCLES = 30;
   localparam int ITEM_GOAL    = 1250;
   localparam int TAIL_ITEMS   = 60;

   typedef cluster_scoreboard #(WINDOW_LEN, GROUP_LIMIT) board_t;

   logic                               clock;
   logic                               reset;
   logic                               req_valid;
   logic                               req_ready;
   logic signed [scw_pkg::COORD_W-1:0] req_point_x;
   logic signed [scw_pkg::COORD_W-1:0] req_point_y;
   logic                               req_scan_start;
   logic                               rsp_valid;
   logic                               rsp_ready;
   logic [scw_pkg::GROUP_W-1:0]        rsp_point_group;
   logic [scw_pkg::BACK_W-1:0]         rsp_back_offset;
   logic                               rsp_back_group_new;
   logic [scw_pkg::SIZE_W-1:0]         rsp_group_size;
   logic [scw_pkg::GROUP_W-1:0]        rsp_groups_total;
   logic                               rsp_groups_overflow;
   logic                               csr_write;
   logic [scw_pkg::DIST_W-1:0]         csr_data;

   board_t      sb;
   int unsigned items_sent;
   bit          tx_idle;
   bit          rx_idle;
   int unsigned hold_cycles;

   scan_point_window_clustering #(
      .WINDOW     (WINDOW_LEN),
      .MAX_GROUPS (GROUP_LIMIT)
   ) u_dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_point_x         (req_point_x),
      .req_point_y         (req_point_y),
      .req_scan_start      (req_scan_start),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_point_group     (rsp_point_group),
      .rsp_back_offset     (rsp_back_offset),
      .rsp_back_group_new  (rsp_back_group_new),
      .rsp_group_size      (rsp_group_size),
      .rsp_groups_total    (rsp_groups_total),
      .rsp_groups_overflow (rsp_groups_overflow),
      .csr_write           (csr_write),
      .csr_data            (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #25_000_000;
      $display("Mismatches found");
      $finish;
   end

   // Sample both channels at the rising edge. Note the point before checking
   // so a same-edge result can never outrun its own prediction.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            sb.note_point(req_point_x, req_point_y, req_scan_start);
         end
         if (rsp_valid && rsp_ready) begin
            sb.check_result('{rsp_point_group, rsp_back_offset, rsp_back_group_new,
                              rsp_group_size, rsp_groups_total, rsp_groups_overflow});
         end
      end
   end

   // Result receiver: random stall bursts, plus one long hold-off on request.
   // Each branch makes at most one assignment to rsp_ready per falling edge.
   initial begin
      rsp_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_cycles != 0) begin
            rsp_ready <= 1'b0;
            repeat (hold_cycles) @(negedge clock);
            hold_cycles = 0;
         end else if (rx_idle && $urandom_range(0, 4) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 17)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            @(negedge clock);
         end
      end
   end

   // Offer one point and hold it until the transfer happens. Starts and ends
   // on a falling edge; valid stays high between back-to-back points.
   task automatic send_point(input logic signed [scw_pkg::COORD_W-1:0] x,
                             input logic signed [scw_pkg::COORD_W-1:0] y,
                             input logic start);
      if (tx_idle && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 17)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_point_x    <= x;
      req_point_y    <= y;
      req_scan_start <= start;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      @(negedge clock);
   endtask

   // Drain the block completely, then write the link limit.
   task automatic write_link(input logic [scw_pkg::DIST_W-1:0] value);
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write <= 1'b1;
      csr_data  <= value;
      @(negedge clock);
      csr_write <= 1'b0;
      sb.set_link(value);
   endtask

   // Random walk: mostly small steps so points link, now and then a jump.
   task automatic cluster_scan(input int count);
      logic signed [scw_pkg::COORD_W-1:0] cx;
      logic signed [scw_pkg::COORD_W-1:0] cy;
      cx = 16'($urandom);
      cy = 16'($urandom);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 7) == 0) begin
            cx = 16'($urandom);
            cy = 16'($urandom);
         end else if ($urandom_range(0, 5) != 0) begin
            cx = cx + 16'($urandom_range(0, 300)) - 16'd150;
            cy = cy + 16'($urandom_range(0, 300)) - 16'd150;
         end
         send_point(cx, cy, i == 0);
      end
   endtask

   // Uniform points; scan starts drop in anywhere.
   task automatic noise_scan(input int count);
      for (int i = 0; i < count; i++) begin
         send_point(16'($urandom), 16'($urandom), $urandom_range(0, 7) == 0);
      end
   endtask

   // With a limit of 1 only identical points link. Each fresh point followed
   // by its twin opens one group; run past the last id to force overflow.
   task automatic exhaust_ids();
      logic signed [scw_pkg::COORD_W-1:0] px;
      logic signed [scw_pkg::COORD_W-1:0] py;
      write_link(1);
      send_point(16'($urandom), 16'($urandom), 1'b1);
      for (int i = 1; i < WINDOW_LEN; i++) send_point(16'($urandom), 16'($urandom), 1'b0);
      for (int n = 0; n < GROUP_LIMIT + 3; n++) begin
         px = 16'($urandom);
         py = 16'($urandom);
         send_point(px, py, 1'b0);
         send_point(px, py, 1'b0);
      end
   endtask

   initial begin : stimulus
      int unsigned random_goal;
      logic [scw_pkg::DIST_W-1:0] link_v;

      sb = new;
      sb.clear_state();
      items_sent     = 0;
      tx_idle        = 1'b1;
      rx_idle        = 1'b1;
      hold_cycles    = 0;
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_point_x    = '0;
      req_point_y    = '0;
      req_scan_start = 1'b0;
      csr_write      = 1'b0;
      csr_data       = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part at the reset link limit (200 mm). The first point comes
      // without a scan start and continues the scan left over from reset; a
      // scan start then arrives before the window is full.
      send_point(-16'sd32768, -16'sd32768, 1'b0);
      send_point(16'sd32767, 16'sd32767, 1'b1);
      send_point(-16'sd32768, 16'sd32767, 1'b0);
      send_point(16'sd32767, -16'sd32768, 1'b0);
      for (int k = 1; k <= 10; k++) send_point(16'(k * 1000), 16'sd0, 1'b0);
      send_point(-16'sd7000, 16'sd100, 1'b0);
      send_point(16'sd0, 16'sd0, 1'b0);
      // Window now full. Distance exactly at the limit does not link.
      send_point(-16'sd7000, -16'sd100, 1'b0);
      // Tie between two neighbors: the most recent one wins and opens a group.
      send_point(-16'sd7000, 16'sd0, 1'b0);
      // Join the group just opened.
      send_point(-16'sd7000, 16'sd10, 1'b0);
      // Open a group on an older neighbor, several points back.
      send_point(16'sd0, 16'sd150, 1'b0);
      // No neighbor close enough.
      send_point(16'sd20000, -16'sd20000, 1'b0);
      // Just inside the limit, far back in the window.
      send_point(16'sd10000, 16'sd199, 1'b0);
      send_point(-16'sd32768, -16'sd32768, 1'b0);

      // Random part, up to the item count less the closing scan.
      random_goal = ITEM_GOAL - TAIL_ITEMS;
      exhaust_ids();
      write_link(scw_pkg::LINK_RESET);
      // Hold the receiver off while points keep coming, so the block fills up.
      hold_cycles = 400;
      cluster_scan(40);
      write_link('0);
      cluster_scan(30);
      write_link('1);
      noise_scan(30);
      cluster_scan(30);
      while (items_sent < random_goal) begin
         tx_idle = $urandom_range(0, 3) != 0;
         rx_idle = $urandom_range(0, 3) != 0;
         if ($urandom_range(0, 2) == 0) begin
            case ($urandom_range(0, 4))
               0: link_v = '0;
               1: link_v = '1;
               2: link_v = scw_pkg::LINK_RESET;
               3: link_v = {1'($urandom), 32'($urandom)};
               default: link_v = $urandom_range(1, 2000000);
            endcase
            write_link(link_v);
         end
         if ($urandom_range(0, 3) == 0) noise_scan($urandom_range(5, 40));
         else cluster_scan($urandom_range(16, 60));
      end

      // Last part, no idling: one scan of a single spot keeps one group growing
      // with every point once the window is full.
      tx_idle = 1'b0;
      rx_idle = 1'b0;
      write_link(scw_pkg::LINK_RESET);
      send_point(16'sd100, 16'sd100, 1'b1);
      repeat (TAIL_ITEMS - 1) send_point(16'sd100, 16'sd100, 1'b0);

      // Drop valid, wait for every result, then let the pipeline settle.
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (sb.mismatches == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule

[sim.f]
design/scw_pkg.sv
design/scw_cell.sv
design/scw_dist.sv
design/scan_point_window_clustering.sv
test/scan_point_window_clustering_test.sv
